### hw/rtl/udp_ack_pkg.sv
// Package with the command, opcode, status and reply-mode codes of the UDP session ack handler.
package udp_ack_pkg;

    localparam logic [1:0] CMD_HEADER  = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_CLOSE   = 2'd2;

    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_OPEN    = 3'd1;
    localparam logic [2:0] OP_ACCEPT  = 3'd2;
    localparam logic [2:0] OP_REJECT  = 3'd3;
    localparam logic [2:0] OP_CLOSING = 3'd4;
    localparam logic [2:0] OP_CLOSED  = 3'd5;

    localparam logic [15:0] OPEN_SESSION_ID = {8'h13, 8'h37};

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_OPEN  = 2'd1,
        MODE_ACK   = 2'd2,
        MODE_CLOSE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_NONE       = 3'd0,
        ST_WRITE_ONLY = 3'd1,
        ST_WRITE      = 3'd2,
        ST_ACCEPTED   = 3'd3,
        ST_CLOSING    = 3'd4,
        ST_CLOSED     = 3'd5,
        ST_REJECTED   = 3'd6,
        ST_ERROR      = 3'd7
    } status_t;

endpackage

### hw/rtl/udp_session_ack_handler_core.sv
// Client-side reliable-UDP session reply engine: one request in, one status and reply header out.
// Each accepted request produces exactly one registered result; a new request is taken in
// every cycle while the output is not stalled (s_ready = !m_valid || m_ready), so the
// sustained rate is one request per clock while m_ready stays high. The session state and
// the result register update at the same edge, so the result register is the only pipeline
// stage. The reply fields always show the reply header held after the request (nothing,
// open, ack or close); payload_length is nonzero only for status write.
module udp_session_ack_handler_core
    import udp_ack_pkg::*;
#(
    parameter int REMOTE_ID_BITS = 15,
    parameter int LENGTH_BITS    = 11
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_command,
    input  logic                      s_rx_syn,
    input  logic                      s_rx_ack_request,
    input  logic [2:0]                s_rx_opcode,
    input  logic [15:0]               s_rx_session_id,
    input  logic [REMOTE_ID_BITS-1:0] s_rx_remote_id,
    input  logic [LENGTH_BITS-1:0]    s_rx_length,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_status,
    output logic [1:0]                m_tx_kind,
    output logic                      m_tx_retransmit,
    output logic [2:0]                m_tx_opcode,
    output logic [15:0]               m_tx_session_id,
    output logic [REMOTE_ID_BITS-1:0] m_tx_ack_id,
    output logic [LENGTH_BITS-1:0]    m_payload_length
);

    mode_t                     mode_reg, mode_next;
    logic [REMOTE_ID_BITS-1:0] last_rid_reg, last_rid_next;
    logic                      open_retx_reg, open_retx_next;
    logic [15:0]               ack_session_reg, ack_session_next;
    logic [REMOTE_ID_BITS-1:0] ack_number_reg, ack_number_next;
    logic [15:0]               close_session_reg, close_session_next;
    logic                      close_retx_reg, close_retx_next;
    logic                      close_closed_reg, close_closed_next;
    logic [15:0]               last_rx_session_reg, last_rx_session_next;

    logic                      m_valid_reg, m_valid_next;
    status_t                   status_reg, status_next;
    logic [1:0]                tx_kind_reg, tx_kind_next;
    logic                      tx_retx_reg, tx_retx_next;
    logic [2:0]                tx_opcode_reg, tx_opcode_next;
    logic [15:0]               tx_session_reg, tx_session_next;
    logic [REMOTE_ID_BITS-1:0] tx_ack_reg, tx_ack_next;
    logic [LENGTH_BITS-1:0]    plen_reg, plen_next;

    logic                      accept;
    logic                      in_order;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign in_order = (s_rx_remote_id == last_rid_reg + REMOTE_ID_BITS'(1));

    always_comb begin
        mode_next            = mode_reg;
        last_rid_next        = last_rid_reg;
        open_retx_next       = open_retx_reg;
        ack_session_next     = ack_session_reg;
        ack_number_next      = ack_number_reg;
        close_session_next   = close_session_reg;
        close_retx_next      = close_retx_reg;
        close_closed_next    = close_closed_reg;
        last_rx_session_next = last_rx_session_reg;
        status_next          = ST_NONE;
        plen_next            = '0;
        unique case (s_command)
            CMD_HEADER: begin
                last_rx_session_next = s_rx_session_id;
                if (mode_reg == MODE_CLOSE) begin
                    close_retx_next   = 1'b1;
                    close_closed_next = 1'b0;
                    if (s_rx_syn && s_rx_opcode == OP_CLOSED) begin
                        status_next = ST_CLOSED;
                    end else begin
                        if (s_rx_syn && s_rx_opcode == OP_CLOSING) begin
                            close_retx_next   = 1'b0;
                            close_closed_next = 1'b1;
                        end
                        close_session_next = s_rx_session_id;
                        status_next        = ST_WRITE_ONLY;
                    end
                end else if (s_rx_ack_request) begin
                    ack_session_next = s_rx_session_id;
                    if (in_order) begin
                        ack_number_next = s_rx_remote_id;
                        last_rid_next   = s_rx_remote_id;
                        plen_next       = s_rx_length;
                        status_next     = ST_WRITE;
                    end else begin
                        ack_number_next = last_rid_reg;
                        status_next     = ST_WRITE_ONLY;
                    end
                end else if (!s_rx_syn) begin
                    status_next = ST_NONE;
                end else if (s_rx_opcode == OP_ACCEPT) begin
                    ack_session_next = s_rx_session_id;
                    ack_number_next  = '0;
                    if (mode_reg == MODE_ACK) begin
                        status_next = ST_WRITE_ONLY;
                    end else begin
                        mode_next     = MODE_ACK;
                        last_rid_next = '0;
                        status_next   = ST_ACCEPTED;
                    end
                end else if (s_rx_opcode == OP_CLOSING) begin
                    close_retx_next    = 1'b0;
                    close_session_next = s_rx_session_id;
                    close_closed_next  = 1'b1;
                    mode_next          = MODE_CLOSE;
                    status_next        = ST_CLOSING;
                end else if (s_rx_opcode == OP_REJECT) begin
                    status_next = ST_REJECTED;
                end else begin
                    status_next = ST_ERROR;
                end
            end
            CMD_RESTART: begin
                open_retx_next = (mode_reg == MODE_OPEN);
                mode_next      = MODE_OPEN;
            end
            CMD_CLOSE: begin
                close_retx_next    = 1'b0;
                close_closed_next  = 1'b0;
                close_session_next = last_rx_session_reg;
                mode_next          = MODE_CLOSE;
            end
            default: begin
                status_next = ST_ERROR;
            end
        endcase
    end

    always_comb begin
        tx_kind_next    = mode_next;
        tx_retx_next    = 1'b0;
        tx_opcode_next  = OP_NONE;
        tx_session_next = '0;
        tx_ack_next     = '0;
        unique case (mode_next)
            MODE_OPEN: begin
                tx_retx_next    = open_retx_next;
                tx_opcode_next  = OP_OPEN;
                tx_session_next = OPEN_SESSION_ID;
            end
            MODE_ACK: begin
                tx_session_next = ack_session_next;
                tx_ack_next     = ack_number_next;
            end
            MODE_CLOSE: begin
                tx_retx_next    = close_retx_next;
                tx_opcode_next  = close_closed_next ? OP_CLOSED : OP_CLOSING;
                tx_session_next = close_session_next;
            end
            default: begin
                tx_kind_next = MODE_IDLE;
            end
        endcase
    end

    assign m_valid_next = accept || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg            <= MODE_IDLE;
            last_rid_reg        <= '0;
            open_retx_reg       <= 1'b0;
            ack_session_reg     <= '0;
            ack_number_reg      <= '0;
            close_session_reg   <= '0;
            close_retx_reg      <= 1'b0;
            close_closed_reg    <= 1'b0;
            last_rx_session_reg <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                mode_reg            <= mode_next;
                last_rid_reg        <= last_rid_next;
                open_retx_reg       <= open_retx_next;
                ack_session_reg     <= ack_session_next;
                ack_number_reg      <= ack_number_next;
                close_session_reg   <= close_session_next;
                close_retx_reg      <= close_retx_next;
                close_closed_reg    <= close_closed_next;
                last_rx_session_reg <= last_rx_session_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg     <= status_next;
            tx_kind_reg    <= tx_kind_next;
            tx_retx_reg    <= tx_retx_next;
            tx_opcode_reg  <= tx_opcode_next;
            tx_session_reg <= tx_session_next;
            tx_ack_reg     <= tx_ack_next;
            plen_reg       <= plen_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_tx_kind        = tx_kind_reg;
    assign m_tx_retransmit  = tx_retx_reg;
    assign m_tx_opcode      = tx_opcode_reg;
    assign m_tx_session_id  = tx_session_reg;
    assign m_tx_ack_id      = tx_ack_reg;
    assign m_payload_length = plen_reg;

`ifndef SYNTH
    a_plen_only_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_WRITE |-> m_payload_length == '0)
        else $error("payload length set without write status");

    a_idle_reply_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_kind == MODE_IDLE |-> !m_tx_retransmit && m_tx_opcode == OP_NONE
        && m_tx_session_id == '0 && m_tx_ack_id == '0)
        else $error("idle reply carries header fields");

    a_accepted_enters_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_ACCEPTED |-> m_tx_kind == MODE_ACK && m_tx_ack_id == '0
        && mode_reg == MODE_ACK)
        else $error("accepted status without ack reply");

    a_closing_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_CLOSING |-> m_tx_kind == MODE_CLOSE
        && m_tx_opcode == OP_CLOSED && !m_tx_retransmit)
        else $error("closing status without closed reply");

    a_state_holds_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(mode_reg) && $stable(last_rid_reg))
        else $error("session state changed without a request");
`endif

endmodule
